// File: rtl/base64_decoder_assert.svh
// ----------------------------------------------------------------------------
// base64_decoder assertion macros
// property shorthands for the decoder checker
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// same-cycle implication
`define B64D_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("base64_decoder: same-cycle check failed");

// next-cycle implication
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("base64_decoder: next-cycle check failed");

`endif

// File: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// types, constants and the character table of the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_PAD   = 8'h3d;
	localparam logic [6:0] CHAR_PLUS  = 7'h2b;
	localparam logic [6:0] CHAR_MINUS = 7'h2d;
	localparam logic [6:0] CHAR_SLASH = 7'h2f;
	localparam logic [6:0] CHAR_UNDER = 7'h5f;
	localparam logic [6:0] CHAR_UA    = 7'h41;
	localparam logic [6:0] CHAR_UZ    = 7'h5a;
	localparam logic [6:0] CHAR_LA    = 7'h61;
	localparam logic [6:0] CHAR_LZ    = 7'h7a;
	localparam logic [6:0] CHAR_D0    = 7'h30;
	localparam logic [6:0] CHAR_D9    = 7'h39;

	localparam logic [5:0] SEXT_62 = 6'd62;
	localparam logic [5:0] SEXT_63 = 6'd63;

	typedef enum logic [1:0] {
		KIND_SKIP,
		KIND_PAD,
		KIND_BAD,
		KIND_DATA
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] sextet;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
		logic       bad_input;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sext_t;

	function automatic sext_t sextet_of(input logic [6:0] c);
		sext_t r;
		r.ok  = 1'b1;
		r.val = '0;
		if (c >= CHAR_UA && c <= CHAR_UZ) begin
			r.val = 6'(c - CHAR_UA);
		end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
			r.val = 6'(c - CHAR_LA + 7'd26);
		end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
			r.val = 6'(c - CHAR_D0 + 7'd52);
		end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
			r.val = SEXT_62;
		end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
			r.val = SEXT_63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// accepts characters and sorts them into skip, padding, bad and data items
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       last_char,
	output logic       cmd_push,
	output cmd_t       cmd,
	input  logic       cmd_full
);

	sext_t lut;

	assign lut      = sextet_of(char_in[6:0]);
	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;

	always_comb begin
		cmd.last   = last_char;
		cmd.sextet = lut.val;
		if (char_in == CHAR_SPACE || (char_in >= CHAR_TAB && char_in <= CHAR_CR)) begin
			cmd.kind = KIND_SKIP;
		end else if (char_in == CHAR_PAD) begin
			cmd.kind = KIND_PAD;
		end else if (char_in[7] || !lut.ok) begin
			cmd.kind = KIND_BAD;
		end else begin
			cmd.kind = KIND_DATA;
		end
	end

endmodule

// File: rtl/b64d_cmdq.sv
// ----------------------------------------------------------------------------
// b64d_cmdq
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module b64d_cmdq import b64d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic empty
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full   = cnt_q == CMDQ_CW'(CMDQ_DEPTH);
	assign empty  = cnt_q == '0;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// bit gathering, byte emission, error and padding tracking, result queue
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       has_byte,
	output logic       end_of_message,
	output logic       bad_input
);

	logic [5:0]  bits_q;
	logic [2:0]  cnt_q;
	logic        err_q;
	logic        pad_q;
	res_t        res_q [2];
	logic        rq_wr_q;
	logic        rq_rd_q;
	logic [1:0]  rq_cnt_q;

	logic [5:0]  bits_n;
	logic [2:0]  cnt_n;
	logic        err_n;
	logic        pad_n;
	logic        got;
	logic [7:0]  byte_v;
	logic [11:0] total;
	logic        emit;
	logic        do_pop;
	res_t        res_n;
	res_t        head;

	assign cmd_pop = !cmd_empty && rq_cnt_q != 2'd2;
	assign total   = {bits_q, cmd.sextet};
	assign emit    = cmd_pop && (got || cmd.last);
	assign empty   = rq_cnt_q == 2'd0;
	assign do_pop  = pop && !empty;

	always_comb begin
		bits_n = bits_q;
		cnt_n  = cnt_q;
		err_n  = err_q;
		pad_n  = pad_q;
		got    = 1'b0;
		byte_v = '0;
		case (cmd.kind)
			KIND_SKIP: begin
			end
			KIND_PAD: begin
				pad_n = 1'b1;
			end
			KIND_BAD: begin
				err_n = 1'b1;
			end
			KIND_DATA: begin
				if (pad_q) begin
					err_n = 1'b1;
				end else begin
					case (cnt_q)
						3'd0: begin
							bits_n = cmd.sextet;
							cnt_n  = 3'd6;
						end
						3'd2: begin
							byte_v = total[7:0];
							bits_n = '0;
							cnt_n  = 3'd0;
							got    = 1'b1;
						end
						3'd4: begin
							byte_v = total[9:2];
							bits_n = {4'b0, total[1:0]};
							cnt_n  = 3'd2;
							got    = 1'b1;
						end
						3'd6: begin
							byte_v = total[11:4];
							bits_n = {2'b0, total[3:0]};
							cnt_n  = 3'd4;
							got    = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		res_n.data_byte      = byte_v;
		res_n.has_byte       = got;
		res_n.end_of_message = cmd.last;
		res_n.bad_input      = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			cnt_q  <= '0;
			err_q  <= 1'b0;
			pad_q  <= 1'b0;
		end else if (cmd_pop) begin
			if (cmd.last) begin
				bits_q <= '0;
				cnt_q  <= '0;
				err_q  <= 1'b0;
				pad_q  <= 1'b0;
			end else begin
				bits_q <= bits_n;
				cnt_q  <= cnt_n;
				err_q  <= err_n;
				pad_q  <= pad_n;
			end
		end
	end

	// result queue, two entries
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q[rq_wr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= '0;
		end else begin
			if (emit) begin
				rq_wr_q <= !rq_wr_q;
			end
			if (do_pop) begin
				rq_rd_q <= !rq_rd_q;
			end
			if (emit && !do_pop) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (do_pop && !emit) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

	assign head           = res_q[rq_rd_q];
	assign data_byte      = head.data_byte;
	assign has_byte       = head.has_byte;
	assign end_of_message = head.end_of_message;
	assign bad_input      = head.bad_input;

endmodule

// File: rtl/base64_decoder.sv
// ----------------------------------------------------------------------------
// base64_decoder
// streaming base64 decoder, one character per item, both alphabets
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  input    | push / full      | char_in[7:0], last_char
//  result   | empty / pop      | data_byte[7:0], has_byte, end_of_message,
//           |                  | bad_input
//
//  one item per cycle sustained while results are popped; the table lookup is
//  done as the item is accepted into the command queue, the bit gathering as
//  the back takes it from that queue, and the result is registered in the
//  result queue, whose head shows on the ports until it is popped
//  a four-item command queue parts front and back, a two-entry result
//  queue holds results while pop is low; with that queue full the back
//  stops and full rises once the command queue fills
//  reset clears both queues and all decoder state at once
// ----------------------------------------------------------------------------
module base64_decoder import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       last_char,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       has_byte,
	output logic       end_of_message,
	output logic       bad_input
);

	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_full;
	logic cmd_pop;
	cmd_t cmd_out;
	logic cmd_empty;

	b64d_front u_front (
		.push      (push),
		.full      (full),
		.char_in   (char_in),
		.last_char (last_char),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	b64d_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_cmd (cmd_out),
		.empty  (cmd_empty)
	);

	b64d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_out),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.empty          (empty),
		.pop            (pop),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.bad_input      (bad_input)
	);

endmodule

// File: rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// port-level checks of the base64 decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "base64_decoder_assert.svh"

module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] char_in,
	input logic       last_char,
	input logic       empty,
	input logic       pop,
	input logic [7:0] data_byte,
	input logic       has_byte,
	input logic       end_of_message,
	input logic       bad_input
);

	// an item without a byte only closes a message
	`B64D_ASSERT_NOW(a_nobyte_is_eom, clk, arst_n, !empty && !has_byte, end_of_message)
	// an item without a byte carries a zero data field
	`B64D_ASSERT_NOW(a_nobyte_zero, clk, arst_n, !empty && !has_byte, data_byte == 8'h00)
	// a waiting item holds until taken
	`B64D_ASSERT_NEXT(a_out_hold, clk, arst_n, !empty && !pop,
		!empty && $stable(data_byte) && $stable(has_byte) && $stable(end_of_message) && $stable(bad_input))

endmodule

bind base64_decoder b64d_checker u_b64d_checker (.*);

// File: tb/tb_base64_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_decoder
// self-checking bench for the streaming base64 decoder
// ----------------------------------------------------------------------------
// a short table of directed characters is sent first: padding-only and
// invalid messages, all-ones and all-zeros data, both alphabets, whitespace,
// data after padding. after that come random messages, mostly well-formed
// with mixed alphabets, optional padding and whitespace, plus broken
// messages and raw byte noise. every item goes through a local decoder
// model whose results are queued and compared with each popped result.
// both the push and the pop side idle at random, with quiet stretches.
// ----------------------------------------------------------------------------
module tb_base64_decoder;
	import b64d_pkg::*;

	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_VT = 8'h0b;
	localparam logic [7:0] CH_FF = 8'h0c;
	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM   = 1800;

	typedef enum logic [1:0] {
		ROW_NONE,
		ROW_RES,
		ROW_PRED
	} row_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		row_kind_t  kind;
		res_t       want;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] char_in;
	logic       last_char;
	logic       empty;
	logic       pop;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;
	logic       bad_input;

	// decoder model state
	logic [5:0] mdl_bits;
	logic [2:0] mdl_count;
	logic       mdl_error;
	logic       mdl_padded;

	res_t       decoded_q [$];
	row_t       dir_rows [0:N_DIRECTED-1];
	int         mismatches = 0;
	int         n_items = 0;
	logic       prod_quiet = 1'b0;
	logic       cons_quiet = 1'b0;

	base64_decoder uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.char_in        (char_in),
		.last_char      (last_char),
		.empty          (empty),
		.pop            (pop),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.bad_input      (bad_input)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("base64_decoder verification failed");
		$finish;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	// {valid, sextet}
	function automatic logic [6:0] char_sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return {1'b1, 6'(c - "A")};
		if (c >= "a" && c <= "z")
			return {1'b1, 6'(c - "a" + 8'd26)};
		if (c >= "0" && c <= "9")
			return {1'b1, 6'(c - "0" + 8'd52)};
		if (c == "+" || c == "-")
			return {1'b1, 6'd62};
		if (c == "/" || c == "_")
			return {1'b1, 6'd63};
		return 7'd0;
	endfunction

	function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic alt);
		if (v < 6'd26)
			return 8'("A" + v);
		if (v < 6'd52)
			return 8'("a" + v - 6'd26);
		if (v < 6'd62)
			return 8'("0" + v - 6'd52);
		if (v == 6'd62)
			return alt ? 8'("-") : 8'("+");
		return alt ? 8'("_") : 8'("/");
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return CHAR_SPACE;
			1: return CHAR_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CHAR_CR;
		endcase
	endfunction

	function automatic int idle_len(input logic quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic decode_char(input logic [7:0] c, input logic l,
			output logic hit, output res_t r);
		logic [6:0]  lk;
		logic [11:0] total;
		logic [2:0]  rest;
		logic [7:0]  b;
		logic        got;
		b = 8'h00;
		got = 1'b0;
		lk = char_sextet(c);
		if (is_blank(c)) begin
		end else if (c == CHAR_PAD) begin
			mdl_padded = 1'b1;
		end else if (!lk[6] || mdl_padded) begin
			mdl_error = 1'b1;
		end else if (mdl_count >= 3'd2) begin
			rest = mdl_count - 3'd2;
			total = {mdl_bits, lk[5:0]};
			b = 8'(total >> rest);
			got = 1'b1;
			mdl_bits = 6'(total & ((12'd1 << rest) - 12'd1));
			mdl_count = rest;
		end else begin
			mdl_bits = lk[5:0];
			mdl_count = 3'd6;
		end
		hit = got || l;
		r = '{b, got, l, mdl_error};
		if (l) begin
			mdl_bits = '0;
			mdl_count = '0;
			mdl_error = 1'b0;
			mdl_padded = 1'b0;
		end
	endtask

	task automatic drive_item(input logic [7:0] c, input logic l);
		int gap;
		gap = idle_len(prod_quiet);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		char_in <= c;
		last_char <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		if (!is_blank(c))
			n_items++;
		if ($urandom_range(0, 149) == 0)
			prod_quiet = ($urandom_range(0, 2) == 0);
	endtask

	task automatic send_item(input logic [7:0] c, input logic l);
		logic hit;
		res_t r;
		decode_char(c, l, hit, r);
		if (hit)
			decoded_q.push_back(r);
		drive_item(c, l);
	endtask

	task automatic send_message(input logic broken);
		logic [7:0]  msg [$];
		logic [23:0] w;
		logic        alt;
		logic        mix;
		int          nb;
		int          rem;
		alt = 1'($urandom_range(0, 1));
		mix = ($urandom_range(0, 3) == 0);
		nb = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
		for (int i = 0; i < nb; i += 3) begin
			rem = (nb - i > 3) ? 3 : nb - i;
			w = 24'($urandom);
			for (int k = 0; k <= rem; k++) begin
				if ($urandom_range(0, 9) == 0)
					msg.push_back(blank_char());
				msg.push_back(sextet_char(w[23 - 6 * k -: 6],
					alt ^ (mix & 1'($urandom_range(0, 1)))));
			end
			if (rem < 3 && $urandom_range(0, 3) != 0)
				repeat (3 - rem) msg.push_back(CHAR_PAD);
		end
		if (broken) begin
			if ($urandom_range(0, 1) == 0) begin
				msg.insert($urandom_range(0, msg.size()), 8'($urandom_range(0, 255)));
			end else begin
				msg.push_back(CHAR_PAD);
				msg.push_back(sextet_char(6'($urandom_range(0, 63)), alt));
			end
		end
		if (msg.size() == 0)
			msg.push_back($urandom_range(0, 1) ? CHAR_PAD : blank_char());
		foreach (msg[i])
			send_item(msg[i], i == msg.size() - 1);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// result side
	initial begin
		int   gap;
		res_t want;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = idle_len(cons_quiet);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (decoded_q.size() == 0) begin
				$display("%0t ns: unexpected item, expected none actual %0h/%0b/%0b/%0b",
					$time, data_byte, has_byte, end_of_message, bad_input);
				mismatches++;
			end else begin
				want = decoded_q.pop_front();
				check_field("data_byte", want.data_byte, data_byte);
				check_field("has_byte", 8'(want.has_byte), 8'(has_byte));
				check_field("end_of_message", 8'(want.end_of_message), 8'(end_of_message));
				check_field("bad_input", 8'(want.bad_input), 8'(bad_input));
			end
			if ($urandom_range(0, 63) == 0)
				cons_quiet = ~cons_quiet;
		end
	end

	// input side
	initial begin
		logic hit;
		res_t r;
		int   sel;
		arst_n <= 1'b0;
		push <= 1'b0;
		char_in <= 8'h00;
		last_char <= 1'b0;
		mdl_bits = '0;
		mdl_count = '0;
		mdl_error = 1'b0;
		mdl_padded = 1'b0;
		dir_rows = '{
			'{CHAR_PAD,   1'b1, ROW_RES,  '{8'h00, 1'b0, 1'b1, 1'b0}},
			'{8'hff,      1'b1, ROW_RES,  '{8'h00, 1'b0, 1'b1, 1'b1}},
			'{8'h00,      1'b1, ROW_RES,  '{8'h00, 1'b0, 1'b1, 1'b1}},
			'{"/",        1'b0, ROW_NONE, '0},
			'{"_",        1'b0, ROW_RES,  '{8'hff, 1'b1, 1'b0, 1'b0}},
			'{"/",        1'b0, ROW_RES,  '{8'hff, 1'b1, 1'b0, 1'b0}},
			'{"_",        1'b1, ROW_RES,  '{8'hff, 1'b1, 1'b1, 1'b0}},
			'{"A",        1'b0, ROW_NONE, '0},
			'{"A",        1'b0, ROW_RES,  '{8'h00, 1'b1, 1'b0, 1'b0}},
			'{"A",        1'b0, ROW_RES,  '{8'h00, 1'b1, 1'b0, 1'b0}},
			'{"A",        1'b1, ROW_RES,  '{8'h00, 1'b1, 1'b1, 1'b0}},
			'{"T",        1'b0, ROW_PRED, '0},
			'{CHAR_SPACE, 1'b0, ROW_PRED, '0},
			'{"W",        1'b0, ROW_PRED, '0},
			'{CHAR_TAB,   1'b0, ROW_PRED, '0},
			'{"E",        1'b0, ROW_PRED, '0},
			'{CHAR_PAD,   1'b0, ROW_PRED, '0},
			'{CHAR_PAD,   1'b1, ROW_PRED, '0},
			'{"+",        1'b0, ROW_PRED, '0},
			'{"-",        1'b0, ROW_PRED, '0},
			'{"Q",        1'b0, ROW_PRED, '0},
			'{CHAR_PAD,   1'b0, ROW_PRED, '0},
			'{"Q",        1'b0, ROW_PRED, '0},
			'{8'h80,      1'b0, ROW_PRED, '0},
			'{CHAR_CR,    1'b1, ROW_PRED, '0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			decode_char(dir_rows[i].ch, dir_rows[i].last, hit, r);
			if (dir_rows[i].kind == ROW_RES)
				decoded_q.push_back(dir_rows[i].want);
			else if (dir_rows[i].kind == ROW_PRED && hit)
				decoded_q.push_back(r);
			drive_item(dir_rows[i].ch, dir_rows[i].last);
		end

		n_items = 0;
		while (n_items < N_RANDOM) begin
			sel = $urandom_range(0, 99);
			if (sel < 72)
				send_message(1'b0);
			else if (sel < 88)
				send_message(1'b1);
			else
				repeat ($urandom_range(1, 8))
					send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end
		push <= 1'b0;

		while (decoded_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("base64_decoder verification clean");
		else
			$display("base64_decoder verification failed");
		$finish;
	end

endmodule
